[rtl/core/luma_stats_level_quantizer_assert.svh]
// assertion macros for the luma statistics block
`ifndef LUMA_STATS_LEVEL_QUANTIZER_ASSERT_SVH
`define LUMA_STATS_LEVEL_QUANTIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LSQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsq check failed");
`define LSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsq check failed");
`else
`define LSQ_ASSERT_NOW(lbl, ante, cons)
`define LSQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[rtl/core/lsq_pkg.sv]
`default_nettype none
package lsq_pkg;
  localparam int MAX_PIXELS = 65536;
  localparam int LEVELS     = 6;
  localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int POS_W      = $clog2(MAX_PIXELS + 1);
  localparam int LUMA_W     = 16;
  localparam int DIM_W      = 9;
  localparam int SUM_W      = LUMA_W + ADDR_W;
  localparam int DEV_W      = 2 * LUMA_W + ADDR_W;
  localparam int VAR_W      = 2 * LUMA_W;
  localparam int LVL_W      = 4;
  localparam int CNT_W      = 17;
  localparam int NET_W      = 32;
  localparam int IDX_W      = 16;
  localparam int CH_W       = 16;

  localparam logic [15:0] COEF_R = 16'd19588;
  localparam logic [15:0] COEF_G = 16'd38443;
  localparam logic [15:0] COEF_B = 16'd7504;
  localparam logic [14:0] QROOT_CENTI = 15'd20725;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_LEVEL = 1'b1} cmd_code_t;
  typedef enum logic {CFG_WIDTH = 1'b0, CFG_HEIGHT = 1'b1} cfg_code_t;
  typedef enum logic [1:0] {DIV_MEAN, DIV_VAR, DIV_INDEX} div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     load_wr;
    logic     load_last;
    logic     stats_clr;
    logic     walk_rst;
    logic     walk_step;
    logic     acc_sum;
    logic     acc_dev;
    logic     div_go;
    div_sel_t div_sel;
    logic     mean_ld;
    logic     sqrt_go;
    logic     sd_ld;
    logic     lv_pos;
    logic     emit_stats;
    logic     emit_level;
  } lsq_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic n_zero;
    logic div_done;
    logic sqrt_done;
  } lsq_status_t;
endpackage
`default_nettype wire

[rtl/core/luma_stats_level_quantizer.sv]
// channel   ports                                          handshake
// input     in_cmd in_red in_green in_blue in_last         start && !busy
//           in_pixel_index
// result    out_is_stats out_valid_count out_mean_luma     out_valid, one cycle
//           out_sd_luma out_net_importance out_pixel_level
//           out_empty_error
// config    cfg_index cfg_data                             cfg_valid && cfg_ready
//
// a pixel load holds busy in S_LOAD after the accept (luma multiply and store write).
// a level read waits on the 48-step shared divider splitting the index.
// the last load starts the statistics pass: a walk over the store (store read and
// 3-stage disk test); with pixels inside, a mean divide, walk, variance divide, root.
// reset clears control state and sets width and height to 256; the store is not cleared.
// results cannot be stalled; out_valid marks each for exactly one cycle.
`default_nettype none
`include "luma_stats_level_quantizer_assert.svh"
module luma_stats_level_quantizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [lsq_pkg::CH_W-1:0]          in_red,
  input  logic [lsq_pkg::CH_W-1:0]          in_green,
  input  logic [lsq_pkg::CH_W-1:0]          in_blue,
  input  logic                              in_last,
  input  logic [lsq_pkg::IDX_W-1:0]         in_pixel_index,
  output logic                              out_valid,
  output logic                              out_is_stats,
  output logic [lsq_pkg::CNT_W-1:0]         out_valid_count,
  output logic [lsq_pkg::LUMA_W-1:0]        out_mean_luma,
  output logic [lsq_pkg::LUMA_W-1:0]        out_sd_luma,
  output logic [lsq_pkg::NET_W-1:0]         out_net_importance,
  output logic signed [lsq_pkg::LVL_W-1:0]  out_pixel_level,
  output logic                              out_empty_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [lsq_pkg::DIM_W-1:0]         cfg_data
);
  lsq_pkg::lsq_cmd_t    ctl;
  lsq_pkg::lsq_status_t status;

  assign cfg_ready = 1'b1;

  lsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_cmd),
    .in_last   (in_last),
    .status    (status),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  lsq_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .status             (status),
    .in_red             (in_red),
    .in_green           (in_green),
    .in_blue            (in_blue),
    .in_pixel_index     (in_pixel_index),
    .cfg_wr             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_is_stats       (out_is_stats),
    .out_valid_count    (out_valid_count),
    .out_mean_luma      (out_mean_luma),
    .out_sd_luma        (out_sd_luma),
    .out_net_importance (out_net_importance),
    .out_pixel_level    (out_pixel_level),
    .out_empty_error    (out_empty_error)
  );

  `LSQ_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `LSQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `LSQ_ASSERT_NOW(a_result_idle, out_valid, !busy)
  `LSQ_ASSERT_NOW(a_empty_flag, out_valid && out_is_stats, out_empty_error == (out_valid_count == '0))
endmodule
`default_nettype wire

[rtl/core/lsq_div.sv]
`default_nettype none
module lsq_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [lsq_pkg::DEV_W-1:0]  dividend,
  input  logic [lsq_pkg::POS_W-1:0]  divisor,
  output logic                       done,
  output logic [lsq_pkg::DEV_W-1:0]  quotient,
  output logic [lsq_pkg::POS_W-1:0]  remainder
);
  localparam int STEP_W = $clog2(lsq_pkg::DEV_W + 1);

  logic [STEP_W-1:0]         step_r;
  logic                      run_r;
  logic                      done_r;
  logic [lsq_pkg::DEV_W-1:0] quo_r;
  logic [lsq_pkg::POS_W:0]   rem_r;
  logic [lsq_pkg::POS_W:0]   shifted;
  logic [lsq_pkg::POS_W:0]   diff;
  logic                      fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r[lsq_pkg::POS_W-1:0], quo_r[lsq_pkg::DEV_W-1]};
    fits    = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r  <= 1'b1;
        step_r <= STEP_W'(lsq_pkg::DEV_W);
      end else if (run_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      quo_r <= {quo_r[lsq_pkg::DEV_W-2:0], fits};
      rem_r <= fits ? diff : shifted;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[lsq_pkg::POS_W-1:0];
endmodule
`default_nettype wire

[rtl/core/lsq_dp.sv]
`default_nettype none
module lsq_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lsq_pkg::lsq_cmd_t                 ctl,
  output lsq_pkg::lsq_status_t              status,
  input  logic [lsq_pkg::CH_W-1:0]          in_red,
  input  logic [lsq_pkg::CH_W-1:0]          in_green,
  input  logic [lsq_pkg::CH_W-1:0]          in_blue,
  input  logic [lsq_pkg::IDX_W-1:0]         in_pixel_index,
  input  logic                              cfg_wr,
  input  logic                              cfg_index,
  input  logic [lsq_pkg::DIM_W-1:0]         cfg_data,
  output logic                              out_is_stats,
  output logic [lsq_pkg::CNT_W-1:0]         out_valid_count,
  output logic [lsq_pkg::LUMA_W-1:0]        out_mean_luma,
  output logic [lsq_pkg::LUMA_W-1:0]        out_sd_luma,
  output logic [lsq_pkg::NET_W-1:0]         out_net_importance,
  output logic signed [lsq_pkg::LVL_W-1:0]  out_pixel_level,
  output logic                              out_empty_error
);
  localparam int DIM_W  = lsq_pkg::DIM_W;
  localparam int POS_W  = lsq_pkg::POS_W;
  localparam int LUMA_W = lsq_pkg::LUMA_W;
  localparam int SUM_W  = lsq_pkg::SUM_W;
  localparam int DEV_W  = lsq_pkg::DEV_W;

  // configuration
  logic [DIM_W-1:0] width_r, height_r, w_eff, h_eff;
  // captured item
  logic [lsq_pkg::CH_W-1:0]  red_r, green_r, blue_r;
  logic [lsq_pkg::IDX_W-1:0] idx_r;
  // load side
  logic [POS_W-1:0] pos_r, pos_inc, image_count_r;
  logic             stats_ready_r;
  logic [31:0]      prod_r, prod_g, prod_b;
  logic [33:0]      luma_full;
  logic [17:0]      luma_sh;
  logic [LUMA_W-1:0] luma;
  // store
  logic [LUMA_W-1:0] store_mem [lsq_pkg::MAX_PIXELS];
  logic [LUMA_W-1:0] rdata_r;
  // walk position
  logic [POS_W-1:0] p_r, row_r;
  logic [DIM_W-1:0] col_r, col_inc;
  // disk test pipeline
  logic [DIM_W:0]   two_i, two_j, wx, hx, dx, dy;
  logic             row_in;
  logic [18:0]      a_r, b_r;
  logic [17:0]      c_r;
  logic [37:0]      a2_r, b2_r;
  logic [35:0]      c2_r;
  logic             inr_a_r, inr_b_r, inside_r;
  // accumulators
  logic [SUM_W-1:0]  sum_r;
  logic [POS_W-1:0]  n_r;
  logic [DEV_W-1:0]  dev_r;
  logic [LUMA_W-1:0] mean_r, sd_r, d;
  logic [31:0]       d_sq;
  // divider
  logic [DEV_W-1:0]  div_dividend, div_quo;
  logic [POS_W-1:0]  div_divisor, div_rem;
  logic              div_done;
  // root
  logic [31:0]       sq_x_r;
  logic [15:0]       sq_root_r;
  logic [17:0]       sq_rem_r;
  logic [4:0]        sq_cnt_r;
  logic              sq_run_r, sq_done_r;
  logic [19:0]       sq_sh, sq_trial;
  // results
  logic [SUM_W+14:0] net_prod_r;
  logic [SUM_W+15:0] net_rnd;
  logic [SUM_W-1:0]  net_sh;
  logic [lsq_pkg::NET_W-1:0] net_val;
  logic signed [lsq_pkg::LVL_W-1:0] lvl;

  assign w_eff = (width_r == '0) ? DIM_W'(1) : width_r;
  assign h_eff = (height_r == '0) ? DIM_W'(1) : height_r;

  // luma in Q8.8 with round to nearest
  always_comb begin
    prod_r    = 32'(lsq_pkg::COEF_R) * 32'(red_r);
    prod_g    = 32'(lsq_pkg::COEF_G) * 32'(green_r);
    prod_b    = 32'(lsq_pkg::COEF_B) * 32'(blue_r);
    luma_full = 34'(prod_r) + 34'(prod_g) + 34'(prod_b) + 34'd32768;
    luma_sh   = luma_full[33:16];
    luma      = (luma_sh > 18'd65535) ? '1 : luma_sh[15:0];
    pos_inc   = (pos_r < POS_W'(lsq_pkg::MAX_PIXELS)) ? pos_r + 1'b1 : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= lsq_pkg::DIM_RESET;
      height_r      <= lsq_pkg::DIM_RESET;
      pos_r         <= '0;
      image_count_r <= '0;
      stats_ready_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (lsq_pkg::cfg_code_t'(cfg_index))
          lsq_pkg::CFG_WIDTH:  width_r  <= cfg_data;
          lsq_pkg::CFG_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.load_wr) begin
        stats_ready_r <= 1'b0;
        if (ctl.load_last) begin
          image_count_r <= pos_inc;
          pos_r         <= '0;
        end else begin
          pos_r <= pos_inc;
        end
      end
      if (ctl.emit_stats) stats_ready_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      idx_r   <= in_pixel_index;
    end
  end

  // luma store, registered read
  always_ff @(posedge clk) begin
    if (ctl.load_wr && (pos_r < POS_W'(lsq_pkg::MAX_PIXELS))) begin
      store_mem[lsq_pkg::ADDR_W'(pos_r)] <= luma;
    end
    rdata_r <= store_mem[lsq_pkg::ADDR_W'(p_r)];
  end

  // raster position: column and row follow the pixel counter or the index split
  assign col_inc = col_r + 1'b1;

  always_ff @(posedge clk) begin
    if (ctl.walk_rst) begin
      p_r   <= '0;
      col_r <= '0;
      row_r <= '0;
    end else if (ctl.walk_step) begin
      p_r <= p_r + 1'b1;
      if (col_inc == w_eff) begin
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end else begin
        col_r <= col_inc;
      end
    end else if (ctl.lv_pos) begin
      p_r   <= POS_W'(idx_r);
      col_r <= DIM_W'(div_rem);
      row_r <= POS_W'(div_quo);
    end
  end

  // disk test: (2i-w)^2 h^2 + (h-2j)^2 w^2 <= w^2 h^2, three stages
  always_comb begin
    row_in = 32'(row_r) < 32'(h_eff);
    two_i  = {col_r, 1'b0};
    two_j  = {DIM_W'(row_r), 1'b0};
    wx     = {1'b0, w_eff};
    hx     = {1'b0, h_eff};
    dx     = (two_i >= wx) ? two_i - wx : wx - two_i;
    dy     = (hx >= two_j) ? hx - two_j : two_j - hx;
  end

  always_ff @(posedge clk) begin
    a_r      <= 19'(dx) * 19'(h_eff);
    b_r      <= 19'(dy) * 19'(w_eff);
    c_r      <= 18'(w_eff) * 18'(h_eff);
    inr_a_r  <= row_in;
    a2_r     <= a_r * a_r;
    b2_r     <= b_r * b_r;
    c2_r     <= c_r * c_r;
    inr_b_r  <= inr_a_r;
    inside_r <= inr_b_r && ((39'(a2_r) + 39'(b2_r)) <= 39'(c2_r));
  end

  // accumulators
  always_comb begin
    d    = (rdata_r >= mean_r) ? rdata_r - mean_r : mean_r - rdata_r;
    d_sq = d * d;
  end

  always_ff @(posedge clk) begin
    if (ctl.stats_clr) begin
      sum_r  <= '0;
      n_r    <= '0;
      dev_r  <= '0;
      mean_r <= '0;
      sd_r   <= '0;
    end else begin
      if (ctl.acc_sum && inside_r) begin
        sum_r <= sum_r + SUM_W'(rdata_r);
        n_r   <= n_r + 1'b1;
      end
      if (ctl.acc_dev && inside_r) dev_r <= dev_r + DEV_W'(d_sq);
      if (ctl.mean_ld) mean_r <= LUMA_W'(div_quo);
      if (ctl.sd_ld) sd_r <= sq_root_r;
    end
  end

  // shared divider: mean, variance and raster split of a read index
  always_comb begin
    unique case (ctl.div_sel)
      lsq_pkg::DIV_MEAN: begin
        div_dividend = DEV_W'(sum_r);
        div_divisor  = n_r;
      end
      lsq_pkg::DIV_VAR: begin
        div_dividend = dev_r;
        div_divisor  = n_r;
      end
      lsq_pkg::DIV_INDEX: begin
        div_dividend = DEV_W'(idx_r);
        div_divisor  = POS_W'(w_eff);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  lsq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (ctl.div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // integer square root, two radicand bits per cycle
  always_comb begin
    sq_sh    = {sq_rem_r, sq_x_r[31:30]};
    sq_trial = {2'b00, sq_root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_run_r  <= 1'b0;
      sq_done_r <= 1'b0;
      sq_cnt_r  <= '0;
    end else begin
      sq_done_r <= 1'b0;
      if (ctl.sqrt_go) begin
        sq_run_r <= 1'b1;
        sq_cnt_r <= 5'd16;
      end else if (sq_run_r) begin
        sq_cnt_r <= sq_cnt_r - 1'b1;
        if (sq_cnt_r == 5'd1) begin
          sq_run_r  <= 1'b0;
          sq_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sqrt_go) begin
      sq_x_r    <= lsq_pkg::VAR_W'(div_quo);
      sq_root_r <= '0;
      sq_rem_r  <= '0;
    end else if (sq_run_r) begin
      sq_x_r <= {sq_x_r[29:0], 2'b00};
      if (sq_sh >= sq_trial) begin
        sq_rem_r  <= 18'(sq_sh - sq_trial);
        sq_root_r <= {sq_root_r[14:0], 1'b1};
      end else begin
        sq_rem_r  <= 18'(sq_sh);
        sq_root_r <= {sq_root_r[14:0], 1'b0};
      end
    end
  end

  // total luma times the quarter root of 0.01
  always_ff @(posedge clk) begin
    net_prod_r <= sum_r * lsq_pkg::QROOT_CENTI;
  end

  always_comb begin
    net_rnd = {1'b0, net_prod_r} + (SUM_W + 16)'(32768);
    net_sh  = net_rnd[SUM_W+15:16];
    net_val = (64'(net_sh) > 64'hFFFF_FFFF) ? '1 : lsq_pkg::NET_W'(net_sh);
  end

  // level: largest j with luma >= j*sd; -1 without stats or off the image disk
  always_comb begin
    lvl = '1;
    if (stats_ready_r && (32'(idx_r) < 32'(image_count_r)) && inside_r) begin
      for (int j = 0; j < lsq_pkg::LEVELS; j++) begin
        if (20'(rdata_r) >= 20'(j) * 20'(sd_r)) lvl = lsq_pkg::LVL_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_stats) begin
      out_is_stats       <= 1'b1;
      out_valid_count    <= lsq_pkg::CNT_W'(n_r);
      out_mean_luma      <= mean_r;
      out_sd_luma        <= sd_r;
      out_net_importance <= net_val;
      out_pixel_level    <= '0;
      out_empty_error    <= (n_r == '0);
    end else if (ctl.emit_level) begin
      out_is_stats       <= 1'b0;
      out_valid_count    <= '0;
      out_mean_luma      <= '0;
      out_sd_luma        <= '0;
      out_net_importance <= '0;
      out_pixel_level    <= lvl;
      out_empty_error    <= 1'b0;
    end
  end

  assign status.walk_done = p_r >= image_count_r;
  assign status.n_zero    = (n_r == '0);
  assign status.div_done  = div_done;
  assign status.sqrt_done = sq_done_r;
endmodule
`default_nettype wire

[rtl/core/lsq_ctrl.sv]
`default_nettype none
module lsq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_cmd,
  input  logic                 in_last,
  input  lsq_pkg::lsq_status_t status,
  output lsq_pkg::lsq_cmd_t    ctl,
  output logic                 busy,
  output logic                 out_valid
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_WCHK, S_WWAIT, S_WACC, S_MDIV, S_VDIV, S_ROOT,
    S_STATS, S_LVGO, S_LVDIV, S_LVWAIT, S_LVOUT
  } state_t;

  state_t     state_r, state_nxt;
  logic       phase_r;
  logic       last_r;
  logic [1:0] wcnt_r;
  logic       busy_r;
  logic       out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.capture = 1'b1;
          state_nxt = (lsq_pkg::cmd_code_t'(in_cmd) == lsq_pkg::CMD_LOAD) ? S_LOAD : S_LVGO;
        end
      end
      S_LOAD: begin
        ctl.load_wr   = 1'b1;
        ctl.load_last = last_r;
        if (last_r) begin
          ctl.stats_clr = 1'b1;
          ctl.walk_rst  = 1'b1;
          state_nxt = S_WCHK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WCHK: begin
        if (status.walk_done) begin
          if (phase_r) begin
            ctl.div_go  = 1'b1;
            ctl.div_sel = lsq_pkg::DIV_VAR;
            state_nxt = S_VDIV;
          end else if (status.n_zero) begin
            state_nxt = S_STATS;
          end else begin
            ctl.div_go  = 1'b1;
            ctl.div_sel = lsq_pkg::DIV_MEAN;
            state_nxt = S_MDIV;
          end
        end else begin
          state_nxt = S_WWAIT;
        end
      end
      // store read and disk test settle
      S_WWAIT: begin
        if (wcnt_r == 2'd1) state_nxt = S_WACC;
      end
      S_WACC: begin
        ctl.acc_sum   = !phase_r;
        ctl.acc_dev   = phase_r;
        ctl.walk_step = 1'b1;
        state_nxt = S_WCHK;
      end
      S_MDIV: begin
        ctl.div_sel = lsq_pkg::DIV_MEAN;
        if (status.div_done) begin
          ctl.mean_ld  = 1'b1;
          ctl.walk_rst = 1'b1;
          state_nxt = S_WCHK;
        end
      end
      S_VDIV: begin
        ctl.div_sel = lsq_pkg::DIV_VAR;
        if (status.div_done) begin
          ctl.sqrt_go = 1'b1;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (status.sqrt_done) begin
          ctl.sd_ld = 1'b1;
          state_nxt = S_STATS;
        end
      end
      S_STATS: begin
        ctl.emit_stats = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LVGO: begin
        ctl.div_go  = 1'b1;
        ctl.div_sel = lsq_pkg::DIV_INDEX;
        state_nxt = S_LVDIV;
      end
      S_LVDIV: begin
        ctl.div_sel = lsq_pkg::DIV_INDEX;
        if (status.div_done) begin
          ctl.lv_pos = 1'b1;
          state_nxt = S_LVWAIT;
        end
      end
      S_LVWAIT: begin
        if (wcnt_r == 2'd2) state_nxt = S_LVOUT;
      end
      S_LVOUT: begin
        ctl.emit_level = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      last_r      <= 1'b0;
      wcnt_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= ctl.emit_stats | ctl.emit_level;
      wcnt_r      <= (state_nxt != state_r) ? 2'd0 : wcnt_r + 1'b1;
      if (ctl.capture) last_r <= in_last;
      if (ctl.stats_clr) phase_r <= 1'b0;
      else if (ctl.mean_ld) phase_r <= 1'b1;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

[tb/sv/luma_stats_level_quantizer_test.sv]
`timescale 1ns / 1ps
module luma_stats_level_quantizer_test;
  import lsq_pkg::*;

  typedef struct {
    bit                     is_stats;
    bit [CNT_W-1:0]         count;
    bit [LUMA_W-1:0]        mean;
    bit [LUMA_W-1:0]        sd;
    bit [NET_W-1:0]         net;
    logic signed [LVL_W-1:0] level;
    bit                     empty;
  } lsq_result_t;

  typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_code_t   reg_sel;
    bit [8:0]    reg_val;
    cmd_code_t   cmd;
    bit [15:0]   r, g, b;
    bit          last;
    bit [15:0]   idx;
    bit          typed;
    lsq_result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [CH_W-1:0] in_red = '0, in_green = '0, in_blue = '0;
  logic in_last = 1'b0;
  logic [IDX_W-1:0] in_pixel_index = '0;
  logic out_valid, out_is_stats, out_empty_error;
  logic [CNT_W-1:0] out_valid_count;
  logic [LUMA_W-1:0] out_mean_luma, out_sd_luma;
  logic [NET_W-1:0] out_net_importance;
  logic signed [LVL_W-1:0] out_pixel_level;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [DIM_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  luma_stats_level_quantizer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .in_last(in_last), .in_pixel_index(in_pixel_index),
    .out_valid(out_valid), .out_is_stats(out_is_stats),
    .out_valid_count(out_valid_count), .out_mean_luma(out_mean_luma),
    .out_sd_luma(out_sd_luma), .out_net_importance(out_net_importance),
    .out_pixel_level(out_pixel_level), .out_empty_error(out_empty_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block state
  bit [15:0] luma_mem [0:MAX_PIXELS-1];
  int unsigned fill_pos, pic_count;
  bit [15:0] mean_q, sd_q;
  bit stats_ok;
  bit [8:0] width_reg, height_reg;

  lsq_result_t pending_q[$];
  int fails, items_sent, stats_seen, levels_seen, gap_max;
  plan_row_t plan[$];

  function automatic bit disk_hit(longint unsigned p);
    longint unsigned w, h, i, j, dx, dy;
    w = (width_reg == 0) ? 1 : width_reg;
    h = (height_reg == 0) ? 1 : height_reg;
    if (p >= w * h) return 1'b0;
    i = p % w;
    j = p / w;
    dx = (2 * i >= w) ? 2 * i - w : w - 2 * i;
    dy = (h >= 2 * j) ? h - 2 * j : 2 * j - h;
    return dx * dx * h * h + dy * dy * w * w <= w * w * h * h;
  endfunction

  function automatic longint unsigned int_root(longint unsigned x);
    longint unsigned r;
    r = 0;
    for (int k = 31; k >= 0; k--)
      if ((r | (64'd1 << k)) * (r | (64'd1 << k)) <= x) r |= 64'd1 << k;
    return r;
  endfunction

  function automatic lsq_result_t image_stats();
    lsq_result_t res;
    longint unsigned n, sum, dev2, mean, sdv, net, d;
    n = 0; sum = 0; dev2 = 0; mean = 0; sdv = 0;
    for (int unsigned p = 0; p < pic_count; p++)
      if (disk_hit(p)) begin
        sum += luma_mem[p];
        n++;
      end
    if (n != 0) begin
      mean = sum / n;
      for (int unsigned p = 0; p < pic_count; p++)
        if (disk_hit(p)) begin
          d = (luma_mem[p] >= mean) ? luma_mem[p] - mean : mean - luma_mem[p];
          dev2 += d * d;
        end
      sdv = int_root(dev2 / n);
      if (sdv > 65535) sdv = 65535;
    end
    net = (sum * 20725 + 32768) >> 16;
    if (net > 64'hFFFF_FFFF) net = 64'hFFFF_FFFF;
    mean_q = mean[15:0];
    sd_q = sdv[15:0];
    stats_ok = 1'b1;
    res = '{1'b1, n[16:0], mean[15:0], sdv[15:0], net[31:0], 4'sd0, n == 0};
    return res;
  endfunction

  // updates the shadow state and queues what the item should produce
  task automatic predict_item(cmd_code_t c, bit [15:0] r, g, b, bit lst, bit [15:0] ix);
    longint unsigned luma;
    int lvl;
    lsq_result_t res;
    if (c == CMD_LOAD) begin
      luma = (64'd19588 * r + 64'd38443 * g + 64'd7504 * b + 32768) >> 16;
      if (luma > 65535) luma = 65535;
      stats_ok = 1'b0;
      if (fill_pos < MAX_PIXELS) begin
        luma_mem[fill_pos] = luma[15:0];
        fill_pos++;
      end
      if (lst) begin
        pic_count = fill_pos;
        fill_pos = 0;
        pending_q.push_back(image_stats());
      end
    end else begin
      lvl = -1;
      if (stats_ok && ix < pic_count && disk_hit(ix))
        for (int j = 0; j < LEVELS; j++)
          if (luma_mem[ix] >= j * sd_q) lvl = j;
      res = '{1'b0, '0, '0, '0, '0, lvl[3:0], 1'b0};
      pending_q.push_back(res);
    end
  endtask

  task automatic send_item(cmd_code_t c, bit [15:0] r, g, b, bit lst, bit [15:0] ix);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_cmd = c; in_red = r; in_green = g; in_blue = b;
    in_last = lst; in_pixel_index = ix;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_item(c, r, g, b, lst, ix);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(cfg_code_t sel, bit [8:0] v);
    cfg_valid = 1'b1;
    cfg_index = sel;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    if (sel == CFG_WIDTH) width_reg = v;
    else height_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic void add_load(bit [15:0] r, g, b, bit lst);
    plan_row_t row;
    row = '{ROW_ITEM, CFG_WIDTH, 9'd0, CMD_LOAD, r, g, b, lst, 16'd0, 1'b0,
            '{1'b0, '0, '0, '0, '0, 4'sd0, 1'b0}};
    plan.push_back(row);
  endfunction

  function automatic void add_read(bit [15:0] ix, bit typed);
    plan_row_t row;
    row = '{ROW_ITEM, CFG_WIDTH, 9'd0, CMD_LEVEL, 16'd0, 16'd0, 16'd0, 1'b0, ix, typed,
            '{1'b0, '0, '0, '0, '0, -4'sd1, 1'b0}};
    plan.push_back(row);
  endfunction

  function automatic void add_reg(cfg_code_t sel, bit [8:0] v);
    plan_row_t row;
    row = '{ROW_REG, sel, v, CMD_LOAD, 16'd0, 16'd0, 16'd0, 1'b0, 16'd0, 1'b0,
            '{1'b0, '0, '0, '0, '0, 4'sd0, 1'b0}};
    plan.push_back(row);
  endfunction

  function automatic bit [15:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      3: return 16'($urandom_range(0, 4095));
      default: return 16'($urandom);
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    lsq_result_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing expected");
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (e.is_stats) stats_seen++;
        else levels_seen++;
        if (out_is_stats !== e.is_stats) begin
          $error("is_stats expected %0d got %0d", e.is_stats, out_is_stats); fails++;
        end
        if (out_valid_count !== e.count) begin
          $error("valid_count expected %0d got %0d", e.count, out_valid_count); fails++;
        end
        if (out_mean_luma !== e.mean) begin
          $error("mean_luma expected %0d got %0d", e.mean, out_mean_luma); fails++;
        end
        if (out_sd_luma !== e.sd) begin
          $error("sd_luma expected %0d got %0d", e.sd, out_sd_luma); fails++;
        end
        if (out_net_importance !== e.net) begin
          $error("net_importance expected %0d got %0d", e.net, out_net_importance);
          fails++;
        end
        if (out_pixel_level !== e.level) begin
          $error("pixel_level expected %0d got %0d", e.level, out_pixel_level); fails++;
        end
        if (out_empty_error !== e.empty) begin
          $error("empty_error expected %0d got %0d", e.empty, out_empty_error); fails++;
        end
      end
    end
  end

  initial begin
    #30_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int pic_size, reads, phase;
    bit [8:0] w, h;
    lsq_result_t empty_stats;
    fill_pos = 0; pic_count = 0; mean_q = 0; sd_q = 0; stats_ok = 0;
    width_reg = 9'd256; height_reg = 9'd256;
    gap_max = 11;
    empty_stats = '{1'b1, '0, '0, '0, '0, 4'sd0, 1'b1};

    // directed rows
    add_read(16'd0, 1'b1);
    add_read(16'hFFFF, 1'b1);
    add_load(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    plan[$].typed = 1'b1;
    plan[$].want = empty_stats;
    add_read(16'd0, 1'b1);
    add_reg(CFG_WIDTH, 9'd4);
    add_reg(CFG_HEIGHT, 9'd4);
    for (int k = 0; k < 16; k++)
      case (k % 6)
        0: add_load(16'h0000, 16'h0000, 16'h0000, k == 15);
        1: add_load(16'hFFFF, 16'hFFFF, 16'hFFFF, k == 15);
        2: add_load(16'hFFFF, 16'h0000, 16'h0000, k == 15);
        3: add_load(16'h0000, 16'hFFFF, 16'h0000, k == 15);
        4: add_load(16'h0000, 16'h0000, 16'hFFFF, k == 15);
        default: add_load(16'h0100, 16'h0080, 16'h0040, k == 15);
      endcase
    add_read(16'd5, 1'b0);
    add_read(16'd6, 1'b0);
    add_read(16'd0, 1'b1);
    add_read(16'd16, 1'b1);
    add_load(16'h1234, 16'h5678, 16'h9ABC, 1'b0);
    add_read(16'd5, 1'b1);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_REG) begin
        drain();
        write_reg(plan[k].reg_sel, plan[k].reg_val);
      end else begin
        send_item(plan[k].cmd, plan[k].r, plan[k].g, plan[k].b, plan[k].last, plan[k].idx);
        if (plan[k].typed) begin
          void'(pending_q.pop_back());
          pending_q.push_back(plan[k].want);
        end
      end
    end
    send_item(CMD_LOAD, 16'd7, 16'd7, 16'd7, 1'b1, 16'd0);

    // random phases of geometry, images and level reads
    phase = 0;
    while (items_sent < 1590) begin
      case (phase)
        0: begin w = 1; h = 1; end
        1: begin w = 0; h = 0; end
        2: begin w = 511; h = 511; end
        3: begin w = 256; h = 256; end
        4: begin w = 511; h = 3; end
        5: begin w = 2; h = 2; end
        default: begin
          w = 9'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(1, 16));
          h = 9'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                              : $urandom_range(1, 16));
        end
      endcase
      drain();
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
      repeat ($urandom_range(3, 6)) begin
        pic_size = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 300)
                                                : $urandom_range(1, 30);
        for (int p = 0; p < pic_size; p++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(CMD_LEVEL, 16'd0, 16'd0, 16'd0, 1'b0, 16'($urandom));
          send_item(CMD_LOAD, pick_channel(), pick_channel(), pick_channel(),
                    p == pic_size - 1, 16'($urandom));
        end
        reads = $urandom_range(2, 8);
        repeat (reads)
          case ($urandom_range(0, 9))
            0: send_item(CMD_LEVEL, 16'($urandom), 16'($urandom), 16'($urandom), 1'b1,
                         16'($urandom));
            1: send_item(CMD_LEVEL, 16'd0, 16'd0, 16'd0, 1'b0,
                         16'(pic_size + $urandom_range(0, 2)));
            default: send_item(CMD_LEVEL, 16'd0, 16'd0, 16'd0, 1'b0,
                               16'($urandom_range(0, pic_size - 1)));
          endcase
      end
      phase++;
    end

    // one full 16 by 16 image sent without gaps
    drain();
    write_reg(CFG_WIDTH, 9'd16);
    write_reg(CFG_HEIGHT, 9'd16);
    gap_max = 0;
    for (int p = 0; p < 256; p++)
      send_item(CMD_LOAD, 16'($urandom), 16'($urandom), 16'($urandom), p == 255, 16'd0);
    repeat (6) send_item(CMD_LEVEL, 16'd0, 16'd0, 16'd0, 1'b0, 16'($urandom_range(0, 300)));
    send_item(CMD_LEVEL, 16'd0, 16'd0, 16'd0, 1'b0, 16'd32896);

    start = 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("covered %0d items over %0d geometry phases plus a back-to-back 16x16 image",
             items_sent, phase);
    $display("checked %0d statistics results and %0d level results",
             stats_seen, levels_seen);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
